### rtl/core/rtcc_pkg.sv
`default_nettype none
package rtcc_pkg;

	localparam int HOUR_W   = 4;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int YEAR_W   = 14;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	localparam logic [SECOND_W-1:0] MAX_SECOND   = 6'd59;
	localparam logic [MINUTE_W-1:0] MAX_MINUTE   = 6'd59;
	localparam logic [HOUR_W-1:0]   FIRST_HOUR   = 4'd1;
	localparam logic [HOUR_W-1:0]   LAST_HOUR    = 4'd12;
	localparam logic [HOUR_W-1:0]   HOUR_BEFORE_NOON = 4'd11;
	localparam logic [MONTH_W-1:0]  FIRST_MONTH  = 4'd1;
	localparam logic [MONTH_W-1:0]  LAST_MONTH   = 4'd12;
	localparam logic [MONTH_W-1:0]  FEBRUARY     = 4'd2;
	localparam logic [MONTH_W-1:0]  JULY         = 4'd7;
	localparam logic [DAY_W-1:0]    FIRST_DAY    = 5'd1;
	localparam logic [YEAR_W-1:0]   LAST_YEAR    = 14'd9999;

	typedef struct packed {
		logic [HOUR_W-1:0]   hours;
		logic [MINUTE_W-1:0] minutes;
		logic [SECOND_W-1:0] seconds;
		logic                pm;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [YEAR_W-1:0]   year;
	} rtcc_state_t;

	typedef struct packed {
		logic                cmd;
		logic [HOUR_W-1:0]   hours;
		logic [MINUTE_W-1:0] minutes;
		logic [SECOND_W-1:0] seconds;
		logic                pm;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [YEAR_W-1:0]   year;
	} rtcc_item_t;

	localparam rtcc_state_t RESET_STATE = '{
		hours:   4'd11,
		minutes: 6'd59,
		seconds: 6'd40,
		pm:      1'b1,
		month:   4'd9,
		day:     5'd30,
		year:    14'd2016
	};

	// First half of the year alternates 31/30 starting odd, second half flips.
	function automatic logic [DAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0]  y
	);
		logic [DAY_W-1:0] len;
		if (m <= JULY) begin
			if (m == FEBRUARY) begin
				len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
			end else begin
				len = m[0] ? 5'd31 : 5'd30;
			end
		end else begin
			len = m[0] ? 5'd30 : 5'd31;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

### rtl/core/twelve_hour_clock_calendar.sv
`default_nettype none
// Twelve-hour clock with AM/PM and a month/day/year calendar, starting at
// 11:59:40 PM 09/30/2016 after reset. Each transfer on the input is either
// a one-second tick (cmd 0) or a load of all time and date fields (cmd 1);
// each produces exactly one result carrying the full state afterwards, with
// status 1 when a load was rejected as invalid and nothing changed. The
// block takes one item per cycle unless the input stalls: an item is held in
// an input register, and the next-state logic computes the new time from it
// and writes the state and result registers, so a result passes through the
// input register and then the state register. The input register also
// serves as the skid stage while a result waits; the input stalls only while
// both registers are full and the result is stalled.
module twelve_hour_clock_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [3:0]  load_hours,
	input  logic [5:0]  load_minutes,
	input  logic [5:0]  load_seconds,
	input  logic        load_pm,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	input  logic [13:0] load_year,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	output logic        pm,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [13:0] year,
	output logic        status
);
	import rtcc_pkg::*;

	rtcc_item_t  item_s1;
	logic        valid_s1;
	rtcc_state_t state_q;
	rtcc_state_t next_state;
	logic        next_status;
	logic        status_q;
	logic        out_valid_q;
	logic        in_take;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd     <= cmd;
			item_s1.hours   <= load_hours;
			item_s1.minutes <= load_minutes;
			item_s1.seconds <= load_seconds;
			item_s1.pm      <= load_pm;
			item_s1.month   <= load_month;
			item_s1.day     <= load_day;
			item_s1.year    <= load_year;
		end
	end

	rtcc_next u_next (
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (next_state),
		.status (next_status)
	);

	// The clock state doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RESET_STATE;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= next_state;
			status_q    <= next_status;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign hours     = state_q.hours;
	assign minutes   = state_q.minutes;
	assign seconds   = state_q.seconds;
	assign pm        = state_q.pm;
	assign month     = state_q.month;
	assign day       = state_q.day;
	assign year      = state_q.year;
	assign status    = status_q;

endmodule
`default_nettype wire

### rtl/core/rtcc_next.sv
`default_nettype none
module rtcc_next (
	input  rtcc_pkg::rtcc_state_t cur,
	input  rtcc_pkg::rtcc_item_t  item,
	output rtcc_pkg::rtcc_state_t nxt,
	output logic                  status
);
	import rtcc_pkg::*;

	rtcc_state_t tick_st;
	rtcc_state_t load_st;
	logic        load_ok;

	always_comb begin
		tick_st = cur;
		if (cur.seconds < MAX_SECOND) begin
			tick_st.seconds = cur.seconds + 6'd1;
		end else begin
			tick_st.seconds = '0;
			if (cur.minutes < MAX_MINUTE) begin
				tick_st.minutes = cur.minutes + 6'd1;
			end else begin
				tick_st.minutes = '0;
				if (cur.hours >= LAST_HOUR) begin
					tick_st.hours = FIRST_HOUR;
				end else begin
					if (cur.hours == HOUR_BEFORE_NOON) begin
						tick_st.pm = ~cur.pm;
						// PM to AM at midnight: advance the calendar
						if (cur.pm) begin
							if (cur.day >= month_length(cur.month, cur.year)) begin
								tick_st.day = FIRST_DAY;
								if (cur.month >= LAST_MONTH) begin
									tick_st.month = FIRST_MONTH;
									tick_st.year  = (cur.year >= LAST_YEAR) ? '0 :
										cur.year + 14'd1;
								end else begin
									tick_st.month = cur.month + 4'd1;
								end
							end else begin
								tick_st.day = cur.day + 5'd1;
							end
						end
					end
					tick_st.hours = cur.hours + 4'd1;
				end
			end
		end
	end

	always_comb begin
		load_st.hours   = item.hours;
		load_st.minutes = item.minutes;
		load_st.seconds = item.seconds;
		load_st.pm      = item.pm;
		load_st.month   = item.month;
		load_st.day     = item.day;
		load_st.year    = item.year;
		load_ok = (item.hours >= FIRST_HOUR) && (item.hours <= LAST_HOUR) &&
			(item.minutes <= MAX_MINUTE) && (item.seconds <= MAX_SECOND) &&
			(item.month >= FIRST_MONTH) && (item.month <= LAST_MONTH) &&
			(item.year <= LAST_YEAR) && (item.day >= FIRST_DAY) &&
			(item.day <= month_length(item.month, item.year));
	end

	always_comb begin
		if (item.cmd == CMD_TICK) begin
			nxt    = tick_st;
			status = STATUS_OK;
		end else if (load_ok) begin
			nxt    = load_st;
			status = STATUS_OK;
		end else begin
			// drop the bad load, keep the time
			nxt    = cur;
			status = STATUS_REJECT;
		end
	end

endmodule
`default_nettype wire

### rtl/core/rtcc_checker.sv
`default_nettype none
module rtcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  hours,
	input logic [5:0]  minutes,
	input logic [5:0]  seconds,
	input logic        pm,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [13:0] year,
	input logic        status
);
	import rtcc_pkg::*;

	logic out_xfer;
	logic in_xfer;
	assign out_xfer = out_valid && !out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hours) && $stable(minutes) &&
			$stable(seconds) && $stable(pm) && $stable(month) && $stable(day) &&
			$stable(year) && $stable(status))
		else $error("stalled result changed");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// a fresh result needs an earlier transfer on the input
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_xfer, 2))
		else $error("result without a transfer");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hours >= FIRST_HOUR && hours <= LAST_HOUR && minutes <= MAX_MINUTE &&
			seconds <= MAX_SECOND && month >= FIRST_MONTH && month <= LAST_MONTH &&
			day >= FIRST_DAY && day <= month_length(month, year) && year <= LAST_YEAR)
		else $error("time or date out of range");

	// a rejected load repeats the previous result's time
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && $past(out_xfer) && status == STATUS_REJECT |->
			hours == $past(hours) && minutes == $past(minutes) &&
			seconds == $past(seconds) && pm == $past(pm) && month == $past(month) &&
			day == $past(day) && year == $past(year))
		else $error("rejected load changed state");

endmodule

bind twelve_hour_clock_calendar rtcc_checker u_rtcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hours     (hours),
	.minutes   (minutes),
	.seconds   (seconds),
	.pm        (pm),
	.month     (month),
	.day       (day),
	.year      (year),
	.status    (status)
);
`default_nettype wire
